>>> src/cmvr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmvr_pkg
// Shared types and constants for the complex matrix-vector rotator.
// ----------------------------------------------------------------------------
package cmvr_pkg;

  localparam int unsigned MaxDegreeDef = 5;
  localparam int unsigned FracBitsDef  = 30;
  localparam int unsigned MinDegree    = 2;

  localparam int unsigned DataW = 32;
  localparam int unsigned AccW  = 40;
  localparam int unsigned IdxW  = 4;
  localparam int unsigned DegW  = 3;

  localparam logic [DegW-1:0] DegreeRst = 3'd2;

  localparam logic OpMatWrite = 1'b0;
  localparam logic OpVecElem  = 1'b1;

  typedef enum logic [1:0] {
    SeqIdle,
    SeqMac,
    SeqDrain,
    SeqEmit
  } seq_state_e;

  typedef struct packed {
    logic                    operation;
    logic [IdxW-1:0]         row;
    logic [IdxW-1:0]         column;
    logic signed [DataW-1:0] value_re;
    logic signed [DataW-1:0] value_im;
    logic                    last_element;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]         result_index;
    logic signed [DataW-1:0] result_re;
    logic signed [DataW-1:0] result_im;
    logic                    saturated;
    logic                    last_result;
  } out_item_t;

endpackage
`default_nettype wire

>>> src/cmvr_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmvr_if
// Valid/ready channels: input items, result items and the degree register.
// ----------------------------------------------------------------------------
interface cmvr_in_if;
  import cmvr_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cmvr_out_if;
  import cmvr_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cmvr_cfg_if;
  import cmvr_pkg::*;
  logic            valid;
  logic            ready;
  logic [DegW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/complex_matrix_vector_rotate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_matrix_vector_rotate
// Complex matrix times multipole vector, Q1.30 fixed point, row results.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                     | handshake
//  cfg_i   | in  | degree (3 bits)                             | valid/ready
//  in_i    | in  | operation, row, column, value_re/im, last   | valid/ready
//  out_o   | out | result_index, result_re/im, saturated, last | valid/ready
//
//  A vector element issues count rows, count = 2*degree+1: one row per
//  cycle through the single matrix read port and the shared complex
//  multiply-accumulate, then the pipeline drains.
//  An element marked last then emits count results, one per cycle when out_o
//  is not stalled, through the accumulator read and output registers.
//  Reset clears control and the accumulator valid bits at once; no sweep.
//  A stalled output holds; new items are taken while the last result waits.
// ----------------------------------------------------------------------------
module complex_matrix_vector_rotate #(
  parameter int unsigned MaxDegree = cmvr_pkg::MaxDegreeDef,
  parameter int unsigned FracBits  = cmvr_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  cmvr_cfg_if.sink           cfg_i,
  cmvr_in_if.sink            in_i,
  cmvr_out_if.source         out_o
);
  import cmvr_pkg::*;

  localparam int unsigned Dim      = 2 * MaxDegree + 1;
  localparam int unsigned MatDepth = Dim * Dim;
  localparam int unsigned MatAW    = $clog2(MatDepth);
  localparam int unsigned RowW     = $clog2(Dim);
  localparam int unsigned CntW     = $clog2(Dim + 1);

  seq_state_e state_q, state_d;

  logic [DegW-1:0]         degree_q;
  logic [CntW-1:0]         count_w;
  logic [RowW-1:0]         last_row;

  logic                    in_acc, is_vec, col_ok, mat_we;
  logic [MatAW-1:0]        mat_waddr;
  logic [2*DataW-1:0]      mat_rd;

  logic signed [DataW-1:0] x_re_q, x_im_q;
  logic                    last_q;
  logic [RowW-1:0]         iss_row_q;
  logic [MatAW-1:0]        addr_q;
  logic                    v1_q, v2_q, v3_q;
  logic [RowW-1:0]         row1_q, row2_q, row3_q;

  logic [CntW-1:0]         em_iss_q;
  logic                    pend_q;
  logic [RowW-1:0]         pend_row_q;
  logic                    out_valid_q;
  out_item_t               out_q;

  logic                    mac_issue, em_issue, em_load, acc_clr;

  logic signed [AccW-1:0]  pr, pi;
  logic                    acc_rd_en;
  logic [RowW-1:0]         acc_rd_addr;
  logic signed [AccW-1:0]  acc_rd_re, acc_rd_im;
  logic signed [AccW-1:0]  acc_wr_re, acc_wr_im;

  logic                    re_clip, im_clip;
  logic signed [DataW-1:0] re_sat, im_sat;

  // ---------------- configuration ----------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= DegreeRst;
    end else if (cfg_i.valid && cfg_i.ready) begin
      degree_q <= cfg_i.data;
    end
  end

  // clamp degree into the supported range
  always_comb begin
    int unsigned eff;
    eff = 32'(degree_q);
    if (eff < MinDegree) begin
      eff = MinDegree;
    end else if (eff > MaxDegree) begin
      eff = MaxDegree;
    end
    count_w = CntW'(2 * eff + 1);
  end

  assign last_row = RowW'(count_w - CntW'(1));

  // ---------------- input decode ----------------
  assign in_i.ready = (state_q == SeqIdle);
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_vec     = in_acc && (in_i.data.operation == OpVecElem);
  assign col_ok     = 32'(in_i.data.column) < 32'(count_w);
  assign mat_we     = in_acc && (in_i.data.operation == OpMatWrite) &&
                      (32'(in_i.data.row) < Dim) && (32'(in_i.data.column) < Dim);
  assign mat_waddr  = MatAW'(32'(in_i.data.row) * Dim + 32'(in_i.data.column));

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SeqIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    mac_issue = 1'b0;
    em_issue  = 1'b0;
    em_load   = 1'b0;
    acc_clr   = 1'b0;
    unique case (state_q)
      SeqIdle: begin
        if (is_vec) begin
          if (col_ok) begin
            state_d = SeqMac;
          end else if (in_i.data.last_element) begin
            state_d = SeqEmit;
          end
        end
      end
      SeqMac: begin
        mac_issue = 1'b1;
        if (iss_row_q == last_row) begin
          state_d = SeqDrain;
        end
      end
      SeqDrain: begin
        if (!(v1_q || v2_q || v3_q)) begin
          state_d = last_q ? SeqEmit : SeqIdle;
        end
      end
      SeqEmit: begin
        em_load  = pend_q && (!out_valid_q || out_o.ready);
        em_issue = (em_iss_q < count_w) && (!pend_q || em_load);
        if (em_load && (pend_row_q == last_row)) begin
          acc_clr = 1'b1;
          state_d = SeqIdle;
        end
      end
      default: state_d = SeqIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_row_q   <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      em_iss_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= mac_issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (in_acc) begin
        iss_row_q <= '0;
        em_iss_q  <= '0;
      end else begin
        if (mac_issue) begin
          iss_row_q <= iss_row_q + RowW'(1);
        end
        if (em_issue) begin
          em_iss_q <= em_iss_q + CntW'(1);
        end
      end
      if (em_issue) begin
        pend_q <= 1'b1;
      end else if (em_load) begin
        pend_q <= 1'b0;
      end
      if (em_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_re_q <= in_i.data.value_re;
      x_im_q <= in_i.data.value_im;
      last_q <= in_i.data.last_element;
      addr_q <= MatAW'(in_i.data.column);
    end else if (mac_issue) begin
      // step down one row of the column
      addr_q <= addr_q + MatAW'(Dim);
    end
    row1_q <= iss_row_q;
    row2_q <= row1_q;
    row3_q <= row2_q;
    if (em_issue) begin
      pend_row_q <= RowW'(em_iss_q);
    end
    if (em_load) begin
      out_q.result_index <= IdxW'(pend_row_q);
      out_q.result_re    <= re_sat;
      out_q.result_im    <= im_sat;
      out_q.saturated    <= re_clip || im_clip;
      out_q.last_result  <= (pend_row_q == last_row);
    end
  end

  // ---------------- datapath ----------------
  cmvr_mat_mem #(
    .Depth (MatDepth),
    .AddrW (MatAW)
  ) u_mat_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mat_we),
    .wr_addr_i (mat_waddr),
    .wr_data_i ({in_i.data.value_re, in_i.data.value_im}),
    .rd_en_i   (mac_issue),
    .rd_addr_i (addr_q),
    .rd_data_o (mat_rd)
  );

  cmvr_cmac #(
    .FracBits (FracBits)
  ) u_cmac (
    .clk_i (clk_i),
    .mr_i  (mat_rd[2*DataW-1:DataW]),
    .mi_i  (mat_rd[DataW-1:0]),
    .xr_i  (x_re_q),
    .xi_i  (x_im_q),
    .pr_o  (pr),
    .pi_o  (pi)
  );

  // read the row accumulator while the products are rounded
  assign acc_rd_en   = v2_q || em_issue;
  assign acc_rd_addr = v2_q ? row2_q : RowW'(em_iss_q);
  assign acc_wr_re   = acc_rd_re + pr;
  assign acc_wr_im   = acc_rd_im + pi;

  cmvr_acc_mem #(
    .Rows (Dim),
    .RowW (RowW)
  ) u_acc_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (acc_rd_en),
    .rd_addr_i (acc_rd_addr),
    .rd_re_o   (acc_rd_re),
    .rd_im_o   (acc_rd_im),
    .wr_en_i   (v3_q),
    .wr_addr_i (row3_q),
    .wr_re_i   (acc_wr_re),
    .wr_im_i   (acc_wr_im),
    .clr_i     (acc_clr)
  );

  // clip to 32 bits when the top bits are not all sign
  assign re_clip = !((&acc_rd_re[AccW-1:DataW-1]) || !(|acc_rd_re[AccW-1:DataW-1]));
  assign im_clip = !((&acc_rd_im[AccW-1:DataW-1]) || !(|acc_rd_im[AccW-1:DataW-1]));
  assign re_sat  = re_clip ? (acc_rd_re[AccW-1] ? {1'b1, {(DataW-1){1'b0}}}
                                                : {1'b0, {(DataW-1){1'b1}}})
                           : acc_rd_re[DataW-1:0];
  assign im_sat  = im_clip ? (acc_rd_im[AccW-1] ? {1'b1, {(DataW-1){1'b0}}}
                                                : {1'b0, {(DataW-1){1'b1}}})
                           : acc_rd_im[DataW-1:0];

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef ASSERT_OFF
  a_emit_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SeqEmit) |-> !(v1_q || v2_q || v3_q))
    else $error("accumulator pipeline busy during emission");

  a_acc_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (!acc_clr && !(acc_rd_en && (acc_rd_addr == row3_q))))
    else $error("accumulator write collides with read or clear");

  a_wb_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (state_q != SeqIdle))
    else $error("item taken before accumulator write-back finished");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_load |=> out_valid_q)
    else $error("loaded result not presented");
`endif

endmodule
`default_nettype wire

>>> src/cmvr_mat_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmvr_mat_mem
// Matrix store: one complex entry per word, one write and one read port.
// ----------------------------------------------------------------------------
module cmvr_mat_mem #(
  parameter int unsigned Depth = 121,
  parameter int unsigned AddrW = 7
) (
  input  logic                           clk_i,
  input  logic                           wr_en_i,
  input  logic [AddrW-1:0]               wr_addr_i,
  input  logic [2*cmvr_pkg::DataW-1:0]   wr_data_i,
  input  logic                           rd_en_i,
  input  logic [AddrW-1:0]               rd_addr_i,
  output logic [2*cmvr_pkg::DataW-1:0]   rd_data_o
);
  import cmvr_pkg::*;

  logic [2*DataW-1:0] mem_q [Depth];
  logic [2*DataW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule
`default_nettype wire

>>> src/cmvr_acc_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmvr_acc_mem
// Row accumulators: complex 40-bit words, valid bit per row, bulk clear.
// ----------------------------------------------------------------------------
module cmvr_acc_mem #(
  parameter int unsigned Rows = 11,
  parameter int unsigned RowW = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                rd_en_i,
  input  logic [RowW-1:0]                     rd_addr_i,
  output logic signed [cmvr_pkg::AccW-1:0]    rd_re_o,
  output logic signed [cmvr_pkg::AccW-1:0]    rd_im_o,
  input  logic                                wr_en_i,
  input  logic [RowW-1:0]                     wr_addr_i,
  input  logic signed [cmvr_pkg::AccW-1:0]    wr_re_i,
  input  logic signed [cmvr_pkg::AccW-1:0]    wr_im_i,
  input  logic                                clr_i
);
  import cmvr_pkg::*;

  logic [2*AccW-1:0] mem_q [Rows];
  logic [2*AccW-1:0] rd_q;
  logic [Rows-1:0]   vld_q;
  logic              rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_re_i, wr_im_i};
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // a row never written since the last clear reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_re_o = rd_vld_q ? rd_q[2*AccW-1:AccW] : '0;
  assign rd_im_o = rd_vld_q ? rd_q[AccW-1:0]      : '0;

endmodule
`default_nettype wire

>>> src/cmvr_cmac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmvr_cmac
// Two-stage complex product: four registered multiplies, then rounding
// to the fraction point and the real/imaginary combine.
// ----------------------------------------------------------------------------
module cmvr_cmac #(
  parameter int unsigned FracBits = 30
) (
  input  logic                               clk_i,
  input  logic signed [cmvr_pkg::DataW-1:0]  mr_i,
  input  logic signed [cmvr_pkg::DataW-1:0]  mi_i,
  input  logic signed [cmvr_pkg::DataW-1:0]  xr_i,
  input  logic signed [cmvr_pkg::DataW-1:0]  xi_i,
  output logic signed [cmvr_pkg::AccW-1:0]   pr_o,
  output logic signed [cmvr_pkg::AccW-1:0]   pi_o
);
  import cmvr_pkg::*;

  localparam int unsigned ProdW = 2 * DataW;

  logic signed [ProdW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [AccW-1:0]  pr_q, pi_q;

  // round half up, keep the low accumulator bits (sums wrap anyway)
  function automatic logic signed [AccW-1:0] rnd(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] s;
    s   = p + (ProdW'(1) << (FracBits - 1));
    rnd = AccW'(s >>> FracBits);
  endfunction

  always_ff @(posedge clk_i) begin
    p_rr_q <= mr_i * xr_i;
    p_ii_q <= mi_i * xi_i;
    p_ri_q <= mr_i * xi_i;
    p_ir_q <= mi_i * xr_i;
    pr_q   <= rnd(p_rr_q) - rnd(p_ii_q);
    pi_q   <= rnd(p_ri_q) + rnd(p_ir_q);
  end

  assign pr_o = pr_q;
  assign pi_o = pi_q;

endmodule
`default_nettype wire
